FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/imht_pkg.sv
// Types and constants for the IPv4 to MAC hash table.
package imht_pkg;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic REG_TABLE_SIZE  = 1'b0;
  localparam logic REG_MAX_ENTRIES = 1'b1;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned POLY_W  = 23;   // 255 * (31^3 + 31^2 + 31 + 1) fits
  localparam logic [CNT_W-1:0] COUNT_MAX = 9'd511;

  typedef enum logic [2:0] {
    H_IDLE = 3'b001,
    H_POLY = 3'b010,
    H_REM  = 3'b100
  } hash_state_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_HASH = 4'b0010,
    S_RD   = 4'b0100,
    S_CHK  = 4'b1000
  } seq_state_t;

  typedef struct packed {
    logic             en;
    logic [KEY_W-1:0] key;
    logic [MAC_W-1:0] mac;
  } store_wr_t;

endpackage

FILE: rtl/imht_hash.sv
// Iterative hash unit: base-31 polynomial, then bit-serial remainder by the table size.
module imht_hash import imht_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  input  logic [CNT_W-1:0] n,
  output logic             done,
  output logic [CNT_W-1:0] slot_start
);

  hash_state_t       state;
  logic [KEY_W-1:0]  key_q;
  logic [CNT_W-1:0]  n_q;
  logic [POLY_W-1:0] acc;
  logic [4:0]        cnt;
  logic [CNT_W-1:0]  r;

  logic [7:0]        key_byte;
  logic [POLY_W-1:0] acc_next;
  logic [CNT_W:0]    trial;
  logic [CNT_W-1:0]  r_next;

  // least significant byte first
  assign key_byte = key_q[{cnt[1:0], 3'b000} +: 8];
  assign acc_next = {acc[POLY_W-6:0], 5'b00000} - acc + {{(POLY_W-8){1'b0}}, key_byte};

  // compare-subtract: r < n keeps 2r+1 below 2n
  assign trial  = {r, acc[POLY_W-1]};
  assign r_next = (trial >= {1'b0, n_q}) ? CNT_W'(trial - {1'b0, n_q}) : trial[CNT_W-1:0];

  assign slot_start = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        H_IDLE: begin
          if (start) begin
            state <= H_POLY;
            cnt   <= '0;
          end
        end
        H_POLY: begin
          if (cnt == 5'd3) begin
            state <= H_REM;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        H_REM: begin
          if (cnt == 5'(POLY_W - 1)) begin
            state <= H_IDLE;
            done  <= 1'b1;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        default: state <= H_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == H_IDLE && start) begin
      key_q <= key;
      n_q   <= n;
      acc   <= '0;
      r     <= '0;
    end else if (state == H_POLY) begin
      acc <= acc_next;
    end else if (state == H_REM) begin
      r   <= r_next;
      acc <= {acc[POLY_W-2:0], 1'b0};
    end
  end

endmodule

FILE: rtl/imht_store.sv
// Slot store: valid, key and MAC memories with a clearing pass for the valid marks.
module imht_store import imht_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  output logic                           ready,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  output logic                           rd_valid,
  output logic [KEY_W-1:0]               rd_key,
  output logic [MAC_W-1:0]               rd_mac,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
  input  store_wr_t                      wr
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic             valid_mem [TABLE_DEPTH];
  logic [KEY_W-1:0] key_mem   [TABLE_DEPTH];
  logic [MAC_W-1:0] mac_mem   [TABLE_DEPTH];

  logic          clearing;
  logic [AW-1:0] clr_idx;

  assign ready = !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == AW'(TABLE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      valid_mem[clr_idx] <= 1'b0;
    end else if (wr.en) begin
      valid_mem[wr_addr] <= 1'b1;
    end
    rd_valid <= valid_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_mem[wr_addr] <= wr.key;
      mac_mem[wr_addr] <= wr.mac;
    end
    rd_key <= key_mem[rd_addr];
    rd_mac <= mac_mem[rd_addr];
  end

endmodule

FILE: rtl/ipv4_to_mac_hash_table.sv
// Top level: register port, probe sequencer and result register of the IPv4 to MAC table.
// One transaction at a time: busy stays high from accept until the result strobe.
// Each transaction runs the polynomial and remainder steps of the hash, a hand-over into the
// probe loop, then a read and a check for each slot probed (1 up to the effective table size).
// A new transaction can be taken in the strobe cycle, not earlier; there is no receiver stall.
// After reset a clearing pass over every slot holds busy high.
`include "assert_macros.svh"

module ipv4_to_mac_hash_table import imht_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              opcode,
  input  logic [KEY_W-1:0]  ip_addr,
  input  logic [MAC_W-1:0]  mac_addr,
  output logic              done,
  output logic [1:0]        status,
  output logic [MAC_W-1:0]  mac_out,
  output logic [7:0]        slot,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned AW        = $clog2(TABLE_DEPTH);
  localparam int unsigned DEPTH_CAP = (TABLE_DEPTH > 511) ? 511 : TABLE_DEPTH;

  seq_state_t       state;
  logic [CNT_W-1:0] table_size;
  logic [CNT_W-1:0] max_entries;
  logic [CNT_W-1:0] entry_count;
  logic             op;
  logic [KEY_W-1:0] key;
  logic [MAC_W-1:0] mac;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] s;
  logic [CNT_W-1:0] visited;

  logic             accept;
  logic [CNT_W-1:0] n_cur;
  logic             hash_done;
  logic [CNT_W-1:0] hash_slot;
  logic             store_ready;
  logic             rd_valid;
  logic [KEY_W-1:0] rd_key;
  logic [MAC_W-1:0] rd_mac;
  store_wr_t        wr;

  logic             hit;
  logic             empty;
  logic             last;
  logic             finish;
  logic             new_ok;
  logic [CNT_W-1:0] s_inc;

  // register port
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      REG_TABLE_SIZE:  prdata = {23'b0, table_size};
      REG_MAX_ENTRIES: prdata = {23'b0, max_entries};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size  <= 9'd256;
      max_entries <= 9'd192;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_TABLE_SIZE:  table_size  <= pwdata[CNT_W-1:0];
        REG_MAX_ENTRIES: max_entries <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one slot, oversize as the full depth, capped at 511
  assign n_cur = (table_size == '0) ? 9'd1 :
                 (table_size > 9'(DEPTH_CAP)) ? 9'(DEPTH_CAP) : table_size;

  assign busy   = (state != S_IDLE) || !store_ready;
  assign accept = start && !busy;

  imht_hash u_hash (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .key        (ip_addr),
    .n          (n_cur),
    .done       (hash_done),
    .slot_start (hash_slot)
  );

  imht_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_store (
    .clk      (clk),
    .rst      (rst),
    .ready    (store_ready),
    .rd_addr  (AW'(s)),
    .rd_valid (rd_valid),
    .rd_key   (rd_key),
    .rd_mac   (rd_mac),
    .wr_addr  (AW'(s)),
    .wr       (wr)
  );

  assign empty  = !rd_valid;
  assign hit    = rd_valid && (rd_key == key);
  assign last   = (visited == n - 9'd1);
  assign finish = empty || hit || last;
  assign new_ok = empty && (entry_count < max_entries);
  assign s_inc  = (s + 9'd1 == n) ? '0 : s + 9'd1;

  always_comb begin
    wr.en  = (state == S_CHK) && (op == OP_INSERT) && (hit || new_ok);
    wr.key = key;
    wr.mac = mac;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            state <= S_RD;
          end
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (finish) begin
            state <= S_IDLE;
            done  <= 1'b1;
            if (op == OP_INSERT && !hit && new_ok && entry_count < COUNT_MAX) begin
              entry_count <= entry_count + 9'd1;
            end
          end else begin
            state <= S_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // transaction payload, probe position and result
  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= opcode;
      key <= ip_addr;
      mac <= mac_addr;
      n   <= n_cur;
    end
    if (state == S_HASH && hash_done) begin
      s       <= hash_slot;
      visited <= '0;
    end else if (state == S_CHK && !finish) begin
      s       <= s_inc;
      visited <= visited + 9'd1;
    end
    if (state == S_CHK && finish) begin
      status  <= ST_OK;
      mac_out <= '0;
      slot    <= 8'(s);
      if (op == OP_LOOKUP) begin
        if (hit) begin
          mac_out <= rd_mac;
        end else begin
          status <= ST_NOT_FOUND;
          slot   <= '0;
        end
      end else if (!(hit || new_ok)) begin
        status <= ST_FULL;
        slot   <= '0;
      end
    end
  end

  `ASSERT_NEXT(a_accept_busy, accept, busy, "busy not raised after accepting a transaction")
  `ASSERT_IMPLIES(a_done_after_check, done, $past(state == S_CHK), "result strobe without a probe check")
  `ASSERT_IMPLIES(a_count_step, !$past(rst) && entry_count != $past(entry_count), entry_count == $past(entry_count) + 9'd1, "entry count moved by other than one")
  `ASSERT_ALWAYS(a_no_write_when_clearing, !(wr.en && !store_ready), "slot written during clearing pass")

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the IPv4 to MAC hash table: directed cases, then random phases.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import imht_pkg::*;

  localparam int unsigned DEPTH = 256;

  typedef struct packed {
    logic [1:0]       status;
    logic [MAC_W-1:0] mac;
    logic [7:0]       slot;
  } arp_reply_t;

  // Shadow copy of the table; works out the reply of every accepted transaction.
  class mac_table_tracker;
    logic [8:0]       size_reg;
    logic [8:0]       limit_reg;
    bit               used [DEPTH];
    logic [KEY_W-1:0] keys [DEPTH];
    logic [MAC_W-1:0] macs [DEPTH];
    logic [CNT_W-1:0] count;
    arp_reply_t       pending_replies [$];
    int               errors;

    function new();
      size_reg  = 9'd256;
      limit_reg = 9'd192;
      foreach (used[i]) used[i] = 1'b0;
      count  = '0;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [8:0] val);
      if (idx == REG_TABLE_SIZE) size_reg = val;
      else limit_reg = val;
    endfunction

    function int unsigned active_slots();
      int unsigned n;
      n = size_reg;
      if (n == 0) n = 1;
      if (n > DEPTH) n = DEPTH;
      return n;
    endfunction

    function int unsigned home_slot(logic [KEY_W-1:0] key, int unsigned n);
      int unsigned h;
      h = 0;
      for (int i = 0; i < 4; i++) h = (h * 31 + key[8*i +: 8]) % n;
      return h;
    endfunction

    function void note_request(logic op, logic [KEY_W-1:0] ip, logic [MAC_W-1:0] mac);
      int unsigned n;
      int unsigned s;
      bit          hit;
      bit          empty;
      arp_reply_t  r;
      n     = active_slots();
      s     = home_slot(ip, n);
      hit   = 1'b0;
      empty = 1'b0;
      for (int unsigned p = 0; p < n; p++) begin
        if (!used[s]) begin
          empty = 1'b1;
          break;
        end
        if (keys[s] == ip) begin
          hit = 1'b1;
          break;
        end
        s = (s + 1) % n;
      end
      r.status = ST_OK;
      r.mac    = '0;
      r.slot   = '0;
      if (op == OP_LOOKUP) begin
        if (hit) begin
          r.mac  = macs[s];
          r.slot = s[7:0];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end else if (hit) begin
        macs[s] = mac;
        r.slot  = s[7:0];
      end else if (empty && count < limit_reg) begin
        used[s] = 1'b1;
        keys[s] = ip;
        macs[s] = mac;
        if (count != COUNT_MAX) count++;
        r.slot = s[7:0];
      end else begin
        r.status = ST_FULL;
      end
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic [1:0] st, logic [MAC_W-1:0] mac, logic [7:0] slt);
      arp_reply_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%t: unexpected result status %0d mac %h slot %0d", $realtime, st, mac, slt);
        return;
      end
      want = pending_replies.pop_front();
      if (st !== want.status || mac !== want.mac || slt !== want.slot) begin
        errors++;
        if (errors <= 10)
          $display("%t: mismatch status exp %0d got %0d, mac exp %h got %h, slot exp %0d got %0d",
                   $realtime, want.status, st, want.mac, mac, want.slot, slt);
      end
    endfunction

    function int pending();
      return pending_replies.size();
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic             opcode;
  logic [KEY_W-1:0] ip_addr;
  logic [MAC_W-1:0] mac_addr;
  logic             done;
  logic [1:0]       status;
  logic [MAC_W-1:0] mac_out;
  logic [7:0]       slot;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  mac_table_tracker sb;

  ipv4_to_mac_hash_table u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_reply(status, mac_out, slot);
  end

  // Holds start high until the block takes the transaction; start is left high.
  task automatic issue(logic op, logic [KEY_W-1:0] ip, logic [MAC_W-1:0] mac);
    start    <= 1'b1;
    opcode   <= op;
    ip_addr  <= ip;
    mac_addr <= mac;
    do @(posedge clk); while (busy);
    sb.note_request(op, ip, mac);
  endtask

  task automatic sender_gap();
    start <= 1'b0;
    repeat ($urandom_range(1, 10)) @(posedge clk);
  endtask

  task automatic quiesce();
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [8:0] val);
    logic [31:0] junk;
    junk = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk[31:9], val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned      phase_size [11] = '{3, 8, 1, 17, 0, 64, 5, 256, 130, 511, 256};
    logic [KEY_W-1:0] key_pool [$];
    logic [KEY_W-1:0] seen_keys [$];
    logic [KEY_W-1:0] ip;
    logic [MAC_W-1:0] mac;
    int unsigned      lim;
    int unsigned      guard;
    bit               idle_on;

    sb       = new();
    rst      = 1'b1;
    start    = 1'b0;
    opcode   = OP_LOOKUP;
    ip_addr  = '0;
    mac_addr = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // clearing pass keeps busy high for a while
    do @(posedge clk); while (busy);

    // reset settings: empty table, both key extremes, overwrite
    issue(OP_LOOKUP, 32'h0000_0000, 48'h0);
    issue(OP_INSERT, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    issue(OP_INSERT, 32'hFFFF_FFFF, 48'h0);
    issue(OP_LOOKUP, 32'h0000_0000, 48'h0);
    issue(OP_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    issue(OP_INSERT, 32'h0000_0000, 48'h0123_4567_89AB);
    issue(OP_LOOKUP, 32'h0000_0000, 48'h0);

    // zero size acts as one slot; a full probe gives full / not found
    quiesce();
    cfg_write(REG_TABLE_SIZE, 9'd0);
    cfg_write(REG_MAX_ENTRIES, 9'd256);
    issue(OP_INSERT, 32'h0000_0000, 48'h5555_AAAA_5555);
    issue(OP_INSERT, 32'h0101_0101, 48'hAAAA_5555_AAAA);
    issue(OP_LOOKUP, 32'h0101_0101, 48'h0);
    issue(OP_LOOKUP, 32'h0000_0000, 48'h0);

    // oversized size clamps; zero limit refuses new keys but not overwrites
    quiesce();
    cfg_write(REG_TABLE_SIZE, 9'd511);
    cfg_write(REG_MAX_ENTRIES, 9'd0);
    issue(OP_INSERT, 32'hC0A8_0001, 48'h0000_1111_2222);
    issue(OP_INSERT, 32'hFFFF_FFFF, 48'h8000_0000_0001);
    issue(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0);

    // shrunk table: high slots stay stored but unreachable
    quiesce();
    cfg_write(REG_TABLE_SIZE, 9'd2);
    cfg_write(REG_MAX_ENTRIES, 9'd256);
    issue(OP_INSERT, 32'hC0A8_0001, 48'h0000_1111_2222);
    issue(OP_INSERT, 32'h0A00_0001, 48'h7FFF_FFFF_FFFE);
    issue(OP_INSERT, 32'hAC10_0001, 48'h1234_5678_9ABC);
    issue(OP_LOOKUP, 32'hFFFF_FFFF, 48'h0);
    issue(OP_LOOKUP, 32'hC0A8_0001, 48'h0);

    seen_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hC0A8_0001, 32'h0A00_0001};

    foreach (phase_size[p]) begin
      quiesce();
      case ($urandom_range(0, 3))
        0: lim = 256;
        1: lim = sb.count + $urandom_range(0, 8);
        default: lim = $urandom_range(1, 256);
      endcase
      if (lim > 256) lim = 256;
      cfg_write(REG_TABLE_SIZE, phase_size[p][8:0]);
      cfg_write(REG_MAX_ENTRIES, lim[8:0]);

      // small working set of keys so that lookups hit and inserts overwrite
      key_pool.delete();
      repeat (6) begin
        ip = $urandom();
        key_pool.push_back(ip);
        seen_keys.push_back(ip);
      end
      repeat (4) key_pool.push_back(seen_keys[$urandom_range(0, seen_keys.size() - 1)]);

      idle_on = (p < 9);
      repeat (40) begin
        if (idle_on && $urandom_range(0, 2) == 0)
          sender_gap();
        if ($urandom_range(0, 99) < 85) ip = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else ip = $urandom();
        mac = MAC_W'({$urandom(), $urandom()});
        issue($urandom_range(0, 1) ? OP_INSERT : OP_LOOKUP, ip, mac);
      end
    end

    start <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 100_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (600) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
